@@ src/obb_pkg.sv @@
// Package: beat types and fixed-point constants for the oriented box overlap test.
`default_nettype none
package obb_pkg;

    // Corner coordinate, sign-extended to a full Q12.4 word
    typedef struct packed {
        logic signed [15:0] y;
        logic signed [15:0] x;
    } t_pt;

    // Index 0..3 box A corners, 4..7 box B corners
    typedef t_pt [7:0] t_corners;

    typedef struct packed {
        logic [31:0] box_a_corner0;
        logic [31:0] box_a_corner1;
        logic [31:0] box_a_corner2;
        logic [31:0] box_a_corner3;
        logic [31:0] box_b_corner0;
        logic [31:0] box_b_corner1;
        logic [31:0] box_b_corner2;
        logic [31:0] box_b_corner3;
    } t_in_beat;

    typedef struct packed {
        logic               collided;
        logic [16:0]        min_overlap;
        logic signed [15:0] axis_x;
        logic signed [15:0] axis_y;
        logic [16:0]        push_distance;
    } t_out_beat;

    localparam int NSQ      = 31;   // root bits of sqrt(len2 * 2^28)
    localparam int NDV      = 15;   // quotient bits of the normalize divide
    localparam int SQ_W     = 63;   // sqrt remainder and trial width
    localparam int DV_W     = 46;   // divide remainder width
    localparam logic [14:0] ONE_Q14 = 15'd16384;
    localparam logic [16:0] SAT17   = 17'd131071;

endpackage
`default_nettype wire

@@ src/obb_chan_if.sv @@
// Interface: valid/ready stream channel carrying one payload beat.
`default_nettype none
interface obb_chan_if #(parameter type T = logic);
    logic valid;
    logic ready;
    T     data;
    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface
`default_nettype wire

@@ src/obb_overlap_test_2d.sv @@
// Top level: pipelined separating-axis overlap test of two oriented rectangles.
// Usage:
//   i_in carries one beat per box pair: four packed corners of box A and of
//   box B (x in bits 15:0, y in bits 31:16, signed Q12.4 in the low
//   min(COORD_BITS,16) bits of each half). o_out returns one beat per input
//   beat: collided flag, minimum overlap (Q13.4), the quarter-turned unit
//   axis (Q1.14) and the push distance overlap/2 + 2.0 (Q13.4).
// Throughput: one beat per cycle, every cycle, when o_out is not stalled.
// Depth: the pipe depth is set by the 31-step square-root pipe (one root
//   bit per stage) and the 15-step normalize divider (one quotient bit per
//   stage) per axis, all four axes running side by side, followed by
//   project / min-max / overlap / select / round stages.
// Stall: the whole pipe advances as one; while the output beat waits on
//   o_out.ready, i_in.ready is low and every stage holds. The output
//   register is the last stage, so a new beat is taken in the same cycle
//   the waiting result leaves.
// Reset: synchronous active-low i_rst_n clears all stage valid bits; no
//   clearing pass, the block is ready right after reset.
`default_nettype none
module obb_overlap_test_2d
    import obb_pkg::*;
#(
    parameter int COORD_BITS = 16
) (
    input  wire         i_clk,
    input  wire         i_rst_n,
    obb_chan_if.sink    i_in,
    obb_chan_if.source  o_out
);

    localparam int CW   = (COORD_BITS < 16) ? COORD_BITS : 16;
    localparam int SH   = 16 - CW;

    // Valid bit positions along the pipe
    localparam int V0    = 0;            // unpacked corners and edges
    localparam int V1    = 1;            // edge squares
    localparam int VSQ0  = 2;            // sqrt init, then NSQ root steps
    localparam int VDV0  = VSQ0 + NSQ + 1;
    localparam int VAX   = VDV0 + NDV + 1;
    localparam int VMUL  = VAX + 1;
    localparam int VSUM  = VMUL + 1;
    localparam int VMM   = VSUM + 1;
    localparam int VOV   = VMM + 1;
    localparam int VSEL  = VOV + 1;
    localparam int VOUT  = VSEL + 1;
    localparam int NSTG  = VOUT + 1;

    logic             en;
    logic [NSTG-1:0]  r_v;

    assign en          = !r_v[VOUT] || o_out.ready;
    assign i_in.ready  = en;
    assign o_out.valid = r_v[VOUT];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= '0;
        end else if (en) begin
            r_v <= {r_v[NSTG-2:0], i_in.valid};
        end
    end

    // ---------------- Stage 0: unpack and edges ----------------
    function automatic logic signed [15:0] sext(input logic [15:0] h);
        logic [15:0] t;
        t = h << SH;
        return $signed(t) >>> SH;
    endfunction

    logic [31:0]              words [0:7];
    t_corners                 n0_c;
    t_corners                 r0_c;
    logic signed [16:0]       r0_dx [0:3];
    logic signed [16:0]       r0_dy [0:3];

    assign words[0] = i_in.data.box_a_corner0;
    assign words[1] = i_in.data.box_a_corner1;
    assign words[2] = i_in.data.box_a_corner2;
    assign words[3] = i_in.data.box_a_corner3;
    assign words[4] = i_in.data.box_b_corner0;
    assign words[5] = i_in.data.box_b_corner1;
    assign words[6] = i_in.data.box_b_corner2;
    assign words[7] = i_in.data.box_b_corner3;

    always_comb begin
        for (int i = 0; i < 8; i++) begin
            n0_c[i].x = sext(words[i][15:0]);
            n0_c[i].y = sext(words[i][31:16]);
        end
    end

    // Axis order: A 0-1, A 0-3, B 0-1, B 0-3
    always_ff @(posedge i_clk) begin
        if (en) begin
            r0_c <= n0_c;
            for (int k = 0; k < 4; k++) begin
                r0_dx[k] <= 17'(n0_c[(k/2)*4 + ((k%2)*2) + 1].x) - 17'(n0_c[(k/2)*4].x);
                r0_dy[k] <= 17'(n0_c[(k/2)*4 + ((k%2)*2) + 1].y) - 17'(n0_c[(k/2)*4].y);
            end
        end
    end

    // ---------------- Stage 1: squares ----------------
    t_corners                 r1_c;
    logic signed [16:0]       r1_dx [0:3];
    logic signed [16:0]       r1_dy [0:3];
    logic [32:0]              r1_sx [0:3];
    logic [32:0]              r1_sy [0:3];

    always_ff @(posedge i_clk) begin
        if (en) begin
            r1_c <= r0_c;
            for (int k = 0; k < 4; k++) begin
                r1_dx[k] <= r0_dx[k];
                r1_dy[k] <= r0_dy[k];
                r1_sx[k] <= 33'(r0_dx[k] * r0_dx[k]);
                r1_sy[k] <= 33'(r0_dy[k] * r0_dy[k]);
            end
        end
    end

    // ---------------- Square root: one root bit per stage ----------------
    t_corners                 r_sq_c    [0:NSQ];
    logic signed [16:0]       r_sq_dx   [0:NSQ][0:3];
    logic signed [16:0]       r_sq_dy   [0:NSQ][0:3];
    logic                     r_sq_zero [0:NSQ][0:3];
    logic [SQ_W-1:0]          r_sq_rem  [0:NSQ][0:3];
    logic [NSQ-1:0]           r_sq_root [0:NSQ][0:3];

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_sq_c[0] <= r1_c;
            for (int k = 0; k < 4; k++) begin
                r_sq_dx[0][k]   <= r1_dx[k];
                r_sq_dy[0][k]   <= r1_dy[k];
                r_sq_zero[0][k] <= (r1_sx[k] == '0) && (r1_sy[k] == '0);
                r_sq_rem[0][k]  <= (SQ_W'(r1_sx[k]) + SQ_W'(r1_sy[k])) << 28;
                r_sq_root[0][k] <= '0;
            end
        end
    end

    for (genvar t = 1; t <= NSQ; t++) begin : g_sq
        localparam int B = NSQ - t;
        logic [SQ_W-1:0] trial [0:3];
        always_comb begin
            for (int k = 0; k < 4; k++) begin
                trial[k] = (SQ_W'(r_sq_root[t-1][k]) << (B + 1))
                         + (SQ_W'(1) << (2 * B));
            end
        end
        always_ff @(posedge i_clk) begin
            if (en) begin
                r_sq_c[t] <= r_sq_c[t-1];
                for (int k = 0; k < 4; k++) begin
                    r_sq_dx[t][k]   <= r_sq_dx[t-1][k];
                    r_sq_dy[t][k]   <= r_sq_dy[t-1][k];
                    r_sq_zero[t][k] <= r_sq_zero[t-1][k];
                    if (r_sq_rem[t-1][k] >= trial[k]) begin
                        r_sq_rem[t][k]  <= r_sq_rem[t-1][k] - trial[k];
                        r_sq_root[t][k] <= r_sq_root[t-1][k] | (NSQ'(1) << B);
                    end else begin
                        r_sq_rem[t][k]  <= r_sq_rem[t-1][k];
                        r_sq_root[t][k] <= r_sq_root[t-1][k];
                    end
                end
            end
        end
    end

    // ---------------- Normalize divide: one quotient bit per stage ----------------
    t_corners                 r_dv_c    [0:NDV];
    logic                     r_dv_zero [0:NDV][0:3];
    logic                     r_dv_negx [0:NDV][0:3];
    logic                     r_dv_negy [0:NDV][0:3];
    logic [NSQ-1:0]           r_dv_s    [0:NDV][0:3];
    logic [DV_W-1:0]          r_dv_rx   [0:NDV][0:3];
    logic [DV_W-1:0]          r_dv_ry   [0:NDV][0:3];
    logic [NDV-1:0]           r_dv_qx   [0:NDV][0:3];
    logic [NDV-1:0]           r_dv_qy   [0:NDV][0:3];

    logic signed [16:0]       magx [0:3];
    logic signed [16:0]       magy [0:3];

    always_comb begin
        for (int k = 0; k < 4; k++) begin
            magx[k] = r_sq_dx[NSQ][k][16] ? -r_sq_dx[NSQ][k] : r_sq_dx[NSQ][k];
            magy[k] = r_sq_dy[NSQ][k][16] ? -r_sq_dy[NSQ][k] : r_sq_dy[NSQ][k];
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_dv_c[0] <= r_sq_c[NSQ];
            for (int k = 0; k < 4; k++) begin
                r_dv_zero[0][k] <= r_sq_zero[NSQ][k];
                r_dv_negx[0][k] <= r_sq_dx[NSQ][k][16];
                r_dv_negy[0][k] <= r_sq_dy[NSQ][k][16];
                r_dv_s[0][k]    <= r_sq_root[NSQ][k];
                r_dv_rx[0][k]   <= (DV_W'(magx[k][15:0]) << 28)
                                 + DV_W'(r_sq_root[NSQ][k] >> 1);
                r_dv_ry[0][k]   <= (DV_W'(magy[k][15:0]) << 28)
                                 + DV_W'(r_sq_root[NSQ][k] >> 1);
                r_dv_qx[0][k]   <= '0;
                r_dv_qy[0][k]   <= '0;
            end
        end
    end

    for (genvar t = 1; t <= NDV; t++) begin : g_dv
        localparam int B = NDV - t;
        logic [DV_W-1:0] dsh [0:3];
        always_comb begin
            for (int k = 0; k < 4; k++) begin
                dsh[k] = DV_W'(r_dv_s[t-1][k]) << B;
            end
        end
        always_ff @(posedge i_clk) begin
            if (en) begin
                r_dv_c[t] <= r_dv_c[t-1];
                for (int k = 0; k < 4; k++) begin
                    r_dv_zero[t][k] <= r_dv_zero[t-1][k];
                    r_dv_negx[t][k] <= r_dv_negx[t-1][k];
                    r_dv_negy[t][k] <= r_dv_negy[t-1][k];
                    r_dv_s[t][k]    <= r_dv_s[t-1][k];
                    if (r_dv_rx[t-1][k] >= dsh[k]) begin
                        r_dv_rx[t][k] <= r_dv_rx[t-1][k] - dsh[k];
                        r_dv_qx[t][k] <= r_dv_qx[t-1][k] | (NDV'(1) << B);
                    end else begin
                        r_dv_rx[t][k] <= r_dv_rx[t-1][k];
                        r_dv_qx[t][k] <= r_dv_qx[t-1][k];
                    end
                    if (r_dv_ry[t-1][k] >= dsh[k]) begin
                        r_dv_ry[t][k] <= r_dv_ry[t-1][k] - dsh[k];
                        r_dv_qy[t][k] <= r_dv_qy[t-1][k] | (NDV'(1) << B);
                    end else begin
                        r_dv_ry[t][k] <= r_dv_ry[t-1][k];
                        r_dv_qy[t][k] <= r_dv_qy[t-1][k];
                    end
                end
            end
        end
    end

    // ---------------- Axis: cap, sign, quarter turn ----------------
    function automatic logic signed [15:0] comp(input logic [NDV-1:0] q,
                                                input logic neg, input logic zero);
        logic [14:0] c;
        c = (q > ONE_Q14) ? ONE_Q14 : q;
        if (zero) return '0;
        return neg ? -$signed({1'b0, c}) : $signed({1'b0, c});
    endfunction

    t_corners                 r_ax_c;
    logic signed [15:0]       r_px [0:3];
    logic signed [15:0]       r_py [0:3];

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_ax_c <= r_dv_c[NDV];
            for (int k = 0; k < 4; k++) begin
                // turned axis (-uy, ux)
                r_px[k] <= -comp(r_dv_qy[NDV][k], r_dv_negy[NDV][k], r_dv_zero[NDV][k]);
                r_py[k] <= comp(r_dv_qx[NDV][k], r_dv_negx[NDV][k], r_dv_zero[NDV][k]);
            end
        end
    end

    // ---------------- Projections ----------------
    logic signed [31:0]       r_mx [0:3][0:7];
    logic signed [31:0]       r_my [0:3][0:7];
    logic signed [15:0]       r_mul_px [0:3];
    logic signed [15:0]       r_mul_py [0:3];

    always_ff @(posedge i_clk) begin
        if (en) begin
            for (int k = 0; k < 4; k++) begin
                r_mul_px[k] <= r_px[k];
                r_mul_py[k] <= r_py[k];
                for (int i = 0; i < 8; i++) begin
                    r_mx[k][i] <= r_ax_c[i].x * r_px[k];
                    r_my[k][i] <= r_ax_c[i].y * r_py[k];
                end
            end
        end
    end

    logic signed [32:0]       r_pr [0:3][0:7];
    logic signed [15:0]       r_sum_px [0:3];
    logic signed [15:0]       r_sum_py [0:3];

    always_ff @(posedge i_clk) begin
        if (en) begin
            for (int k = 0; k < 4; k++) begin
                r_sum_px[k] <= r_mul_px[k];
                r_sum_py[k] <= r_mul_py[k];
                for (int i = 0; i < 8; i++) begin
                    r_pr[k][i] <= 33'(r_mx[k][i]) + 33'(r_my[k][i]);
                end
            end
        end
    end

    // ---------------- Interval ends ----------------
    logic signed [32:0]       r_mn [0:3][0:1];
    logic signed [32:0]       r_mxv [0:3][0:1];
    logic signed [15:0]       r_mm_px [0:3];
    logic signed [15:0]       r_mm_py [0:3];
    logic signed [32:0]       n_mn [0:3][0:1];
    logic signed [32:0]       n_mxv [0:3][0:1];

    always_comb begin
        for (int k = 0; k < 4; k++) begin
            for (int b = 0; b < 2; b++) begin
                n_mn[k][b]  = r_pr[k][b*4];
                n_mxv[k][b] = r_pr[k][b*4];
                for (int i = 1; i < 4; i++) begin
                    if (r_pr[k][b*4+i] < n_mn[k][b])  n_mn[k][b]  = r_pr[k][b*4+i];
                    if (r_pr[k][b*4+i] > n_mxv[k][b]) n_mxv[k][b] = r_pr[k][b*4+i];
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            for (int k = 0; k < 4; k++) begin
                r_mm_px[k] <= r_sum_px[k];
                r_mm_py[k] <= r_sum_py[k];
                for (int b = 0; b < 2; b++) begin
                    r_mn[k][b]  <= n_mn[k][b];
                    r_mxv[k][b] <= n_mxv[k][b];
                end
            end
        end
    end

    // ---------------- Per-axis overlap ----------------
    logic                     r_sep [0:3];
    logic signed [33:0]       r_ov  [0:3];
    logic signed [15:0]       r_ov_px [0:3];
    logic signed [15:0]       r_ov_py [0:3];
    logic signed [33:0]       o1 [0:3];
    logic signed [33:0]       o2 [0:3];

    always_comb begin
        for (int k = 0; k < 4; k++) begin
            o1[k] = 34'(r_mxv[k][0]) - 34'(r_mn[k][1]);
            o2[k] = 34'(r_mxv[k][1]) - 34'(r_mn[k][0]);
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            for (int k = 0; k < 4; k++) begin
                r_ov_px[k] <= r_mm_px[k];
                r_ov_py[k] <= r_mm_py[k];
                // touching ends do not separate
                r_sep[k]   <= (r_mxv[k][0] < r_mn[k][1]) || (r_mxv[k][1] < r_mn[k][0]);
                r_ov[k]    <= (o1[k] < o2[k]) ? o1[k] : o2[k];
            end
        end
    end

    // ---------------- Minimum select, earliest axis wins ties ----------------
    logic [1:0]               sel_l;
    logic [1:0]               sel_r;
    logic [1:0]               sel_b;
    logic                     r_sel_sep;
    logic [32:0]              r_sel_ov;
    logic signed [15:0]       r_sel_px;
    logic signed [15:0]       r_sel_py;

    always_comb begin
        sel_l = (r_ov[1] < r_ov[0]) ? 2'd1 : 2'd0;
        sel_r = (r_ov[3] < r_ov[2]) ? 2'd3 : 2'd2;
        sel_b = (r_ov[sel_r] < r_ov[sel_l]) ? sel_r : sel_l;
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_sel_sep <= r_sep[0] || r_sep[1] || r_sep[2] || r_sep[3];
            r_sel_ov  <= r_ov[sel_b][32:0];
            r_sel_px  <= r_ov_px[sel_b];
            r_sel_py  <= r_ov_py[sel_b];
        end
    end

    // ---------------- Round, saturate, output register ----------------
    logic [34:0]              mo_w;
    logic [34:0]              pd_w;
    t_out_beat                n_out;
    t_out_beat                r_out;

    always_comb begin
        mo_w = (35'(r_sel_ov) + (35'(1) << 13)) >> 14;
        pd_w = (35'(r_sel_ov) + (35'(1) << 20) + (35'(1) << 14)) >> 15;
        n_out = '0;
        if (!r_sel_sep) begin
            n_out.collided      = 1'b1;
            n_out.min_overlap   = (mo_w > 35'(SAT17)) ? SAT17 : mo_w[16:0];
            n_out.push_distance = (pd_w > 35'(SAT17)) ? SAT17 : pd_w[16:0];
            n_out.axis_x        = r_sel_px;
            n_out.axis_y        = r_sel_py;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_out <= n_out;
        end
    end

    assign o_out.data = r_out;

    // ---------------- Assertions ----------------
    a_sep_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out.valid && !o_out.data.collided |->
            o_out.data.min_overlap == '0 && o_out.data.push_distance == '0 &&
            o_out.data.axis_x == '0 && o_out.data.axis_y == '0)
        else $error("separated beat carries nonzero result fields");

    a_push_floor: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out.valid && o_out.data.collided |-> o_out.data.push_distance >= 17'd32)
        else $error("push distance below 2.0 on a collision");

    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !en |=> $stable(r_v))
        else $error("pipe valid bits moved during a stall");

endmodule
`default_nettype wire
